### rtl/i2c_register_access_master_unit_assert.svh
// ----------------------------------------------------------------------------
// I2C register access master - assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_UNIT_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define I2CM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("implication check failed");
`define I2CM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define I2CM_ASSERT_IMP(lbl, ante, cons)
`define I2CM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C register access master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int CFG_DATA_W      = 16;

	localparam logic [1:0] CFG_DEVICE_ADDRESS       = 2'd0;
	localparam logic [1:0] CFG_ACK_TIMEOUT          = 2'd1;
	localparam logic [1:0] CFG_PHASE_TICKS          = 2'd2;
	localparam logic [1:0] CFG_WRITE_RECOVERY_TICKS = 2'd3;

	localparam logic [6:0]  DEVICE_ADDRESS_RST       = 7'd104;
	localparam logic [7:0]  ACK_TIMEOUT_RST          = 8'd250;
	localparam logic [15:0] PHASE_TICKS_RST          = 16'd1;
	localparam logic [15:0] WRITE_RECOVERY_TICKS_RST = 16'd1000;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic       start_req;
		logic       opcode;
		logic [7:0] reg_address;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_error;
	} res_t;

	typedef struct packed {
		logic  valid;
		tick_t item;
	} q_head_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_TX_DEVW,
		ST_ACK_DEVW,
		ST_TX_REG,
		ST_ACK_REG,
		ST_TX_DATA,
		ST_ACK_DATA,
		ST_RSTART,
		ST_TX_DEVR,
		ST_ACK_DEVR,
		ST_RX,
		ST_NACK,
		ST_STOP,
		ST_RECOVER
	} step_t;

endpackage

`default_nettype wire

### rtl/i2c_register_access_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_register_access_master_unit
// I2C master for single-register reads and writes, one bus tick per beat.
// ----------------------------------------------------------------------------
// Every tick beat yields exactly one result beat with the SCL/SDA levels for
// that tick and the transaction status. Ticks are taken one per clock while
// the two-entry intake queue has room; a beat waits at its head until the
// sequencer pops it, and its result is registered as it is popped. The result
// sits in an output register, and the sequencer keeps stepping whenever a beat
// is queued and that register is empty or being drained. Register writes take
// effect at once and belong between transactions.
`default_nettype none

`include "i2c_register_access_master_unit_assert.svh"

module i2c_register_access_master_unit
	import i2cm_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tick_valid,
	output logic             tick_ready,
	input  wire tick_t       tick,
	output logic             res_valid,
	input  wire logic        res_ready,
	output res_t             res,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	q_head_t head;
	logic    pop;
	cfg_wr_t cfg_wr;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	i2cm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.head       (head),
		.pop        (pop)
	);

	i2cm_seq #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	`I2CM_ASSERT_IMP(a_pop_has_head, pop, head.valid)
	`I2CM_ASSERT_IMP(a_done_while_busy, res_valid && res.done_res, res.busy_res)
	`I2CM_ASSERT_IMP(a_idle_lines_high, res_valid && !res.busy_res, res.scl && res.sda_out && res.sda_drive)
	`I2CM_ASSERT_NXT(a_pop_fills_out, pop, res_valid)

endmodule

`default_nettype wire

### rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Tick intake: two-entry queue that decouples the tick source from the
// bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front
	import i2cm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    tick_valid,
	output logic         tick_ready,
	input  wire tick_t   tick,
	output q_head_t      head,
	input  wire logic    pop
);

	tick_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign tick_ready = (count_q != 2'd2);
	assign push       = tick_valid && tick_ready;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: advances the transaction by one tick per queued beat and
// registers the line levels and status for the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq
	import i2cm_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_wr_t cfg_wr,
	input  wire q_head_t head,
	output logic         pop,
	output logic         res_valid,
	input  wire logic    res_ready,
	output res_t         res
);

	localparam int TW = TIMER_WIDTH;
	localparam int LW = (TW > 16) ? TW : 16;
	localparam logic [LW-1:0] TMAX_EXT = LW'({TW{1'b1}});

	function automatic logic [TW-1:0] clamp_lim(input logic [15:0] v);
		logic [LW-1:0] e;
		e = LW'(v);
		if (e > TMAX_EXT) e = TMAX_EXT;
		if (e == '0) e = LW'(1);
		return e[TW-1:0];
	endfunction

	// config
	logic [6:0]  dev_addr_q;
	logic [7:0]  ack_timeout_q;
	logic [15:0] phase_ticks_q;
	logic [15:0] recovery_ticks_q;

	// sequencer state
	step_t         step_q, step_n;
	logic [1:0]    phase_q, phase_n;
	logic [3:0]    cnt_q, cnt_n;
	logic [7:0]    shift_q, shift_n;
	logic [TW-1:0] timer_q, timer_n;
	logic [7:0]    ackw_q, ackw_n;
	logic          op_q, op_n;
	logic [7:0]    reg_q, reg_n;
	logic [7:0]    data_q, data_n;
	logic [7:0]    rx_q, rx_n;
	logic          err_q, err_n;
	logic          done;

	logic          res_valid_q;
	res_t          res_q;

	logic          scl_c, sda_c, drv_c;
	logic [TW-1:0] lim_sel;
	logic          phase_end;
	logic [TW-1:0] timer_tick;
	logic [3:0]    cnt_inc;
	logic [7:0]    shift_rx;
	tick_t         t;

	assign t   = head.item;
	assign pop = head.valid && (!res_valid_q || res_ready);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q       <= DEVICE_ADDRESS_RST;
			ack_timeout_q    <= ACK_TIMEOUT_RST;
			phase_ticks_q    <= PHASE_TICKS_RST;
			recovery_ticks_q <= WRITE_RECOVERY_TICKS_RST;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				CFG_DEVICE_ADDRESS:       dev_addr_q       <= cfg_wr.data[6:0];
				CFG_ACK_TIMEOUT:          ack_timeout_q    <= cfg_wr.data[7:0];
				CFG_PHASE_TICKS:          phase_ticks_q    <= cfg_wr.data;
				CFG_WRITE_RECOVERY_TICKS: recovery_ticks_q <= cfg_wr.data;
				default:                  dev_addr_q       <= dev_addr_q;
			endcase
		end
	end

	assign lim_sel    = (step_q == ST_RECOVER) ? clamp_lim(recovery_ticks_q)
	                                           : clamp_lim(phase_ticks_q);
	assign phase_end  = (({1'b0, timer_q} + (TW+1)'(1)) >= {1'b0, lim_sel});
	assign timer_tick = phase_end ? '0 : timer_q + TW'(1);
	assign cnt_inc    = cnt_q + 4'd1;
	assign shift_rx   = (phase_q == 2'd1 && timer_q == '0) ? {shift_q[6:0], t.sda_in}
	                                                       : shift_q;

	// line levels at the start of the tick
	always_comb begin
		scl_c = 1'b1;
		sda_c = 1'b1;
		drv_c = 1'b1;
		unique case (step_q)
			ST_START, ST_RSTART: begin
				scl_c = (phase_q == 2'd1 || phase_q == 2'd2);
				sda_c = (phase_q <= 2'd1);
			end
			ST_TX_DEVW, ST_TX_REG, ST_TX_DATA, ST_TX_DEVR: begin
				scl_c = (phase_q == 2'd1);
				sda_c = shift_q[7];
			end
			ST_ACK_DEVW, ST_ACK_REG, ST_ACK_DATA, ST_ACK_DEVR, ST_RX: begin
				scl_c = (phase_q == 2'd1);
				drv_c = 1'b0;
			end
			ST_NACK: begin
				scl_c = (phase_q == 2'd1);
			end
			ST_STOP: begin
				scl_c = (phase_q != 2'd0);
				sda_c = (phase_q == 2'd2);
			end
			default: begin
				scl_c = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		step_n  = step_q;
		phase_n = phase_q;
		cnt_n   = cnt_q;
		shift_n = shift_q;
		timer_n = timer_q;
		ackw_n  = ackw_q;
		op_n    = op_q;
		reg_n   = reg_q;
		data_n  = data_q;
		rx_n    = rx_q;
		err_n   = err_q;
		done    = 1'b0;
		unique case (step_q)
			ST_IDLE: begin
				if (t.start_req) begin
					op_n    = t.opcode;
					reg_n   = t.reg_address;
					data_n  = t.write_data;
					err_n   = 1'b0;
					ackw_n  = 8'd0;
					step_n  = ST_START;
					phase_n = 2'd0;
					timer_n = '0;
				end
			end
			ST_START, ST_RSTART: begin
				timer_n = timer_tick;
				if (phase_end) begin
					if (phase_q != 2'd3) begin
						phase_n = phase_q + 2'd1;
					end else begin
						step_n  = (step_q == ST_START) ? ST_TX_DEVW : ST_TX_DEVR;
						phase_n = 2'd0;
						cnt_n   = 4'd0;
						shift_n = {dev_addr_q, (step_q == ST_RSTART)};
					end
				end
			end
			ST_TX_DEVW, ST_TX_REG, ST_TX_DATA, ST_TX_DEVR: begin
				timer_n = timer_tick;
				if (phase_end) begin
					if (phase_q != 2'd2) begin
						phase_n = phase_q + 2'd1;
					end else begin
						phase_n = 2'd0;
						shift_n = {shift_q[6:0], 1'b0};
						cnt_n   = cnt_inc;
						if (cnt_inc >= 4'd8) begin
							ackw_n = 8'd0;
							unique case (step_q)
								ST_TX_DEVW: step_n = ST_ACK_DEVW;
								ST_TX_REG:  step_n = ST_ACK_REG;
								ST_TX_DATA: step_n = ST_ACK_DATA;
								default:    step_n = ST_ACK_DEVR;
							endcase
						end
					end
				end
			end
			ST_ACK_DEVW, ST_ACK_REG, ST_ACK_DATA, ST_ACK_DEVR: begin
				if (phase_q == 2'd0) begin
					timer_n = timer_tick;
					if (phase_end) begin
						phase_n = 2'd1;
					end
				end else if (!t.sda_in) begin
					phase_n = 2'd0;
					timer_n = '0;
					unique case (step_q)
						ST_ACK_DEVW: begin
							step_n  = ST_TX_REG;
							shift_n = reg_q;
							cnt_n   = 4'd0;
						end
						ST_ACK_REG: begin
							if (op_q == OP_WRITE) begin
								step_n  = ST_TX_DATA;
								shift_n = data_q;
								cnt_n   = 4'd0;
							end else begin
								step_n = ST_RSTART;
							end
						end
						ST_ACK_DEVR: begin
							step_n  = ST_RX;
							shift_n = 8'd0;
							cnt_n   = 4'd0;
						end
						default: begin
							step_n = ST_STOP;
						end
					endcase
				end else if (ackw_q >= ack_timeout_q) begin
					err_n   = 1'b1;
					step_n  = ST_STOP;
					phase_n = 2'd0;
					timer_n = '0;
				end else begin
					ackw_n = ackw_q + 8'd1;
				end
			end
			ST_RX: begin
				shift_n = shift_rx;
				timer_n = timer_tick;
				if (phase_end) begin
					if (phase_q != 2'd2) begin
						phase_n = phase_q + 2'd1;
					end else begin
						phase_n = 2'd0;
						cnt_n   = cnt_inc;
						if (cnt_inc >= 4'd8) begin
							rx_n   = shift_rx;
							step_n = ST_NACK;
						end
					end
				end
			end
			ST_NACK, ST_STOP: begin
				timer_n = timer_tick;
				if (phase_end) begin
					if (phase_q != 2'd2) begin
						phase_n = phase_q + 2'd1;
					end else begin
						phase_n = 2'd0;
						if (step_q == ST_NACK) begin
							step_n = ST_STOP;
						end else begin
							done   = 1'b1;
							step_n = (op_q == OP_WRITE && recovery_ticks_q != 16'd0)
							         ? ST_RECOVER : ST_IDLE;
						end
					end
				end
			end
			ST_RECOVER: begin
				timer_n = timer_tick;
				if (phase_end) begin
					step_n  = ST_IDLE;
					phase_n = 2'd0;
				end
			end
			default: begin
				step_n  = ST_IDLE;
				phase_n = 2'd0;
				timer_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			phase_q     <= 2'd0;
			cnt_q       <= 4'd0;
			shift_q     <= 8'd0;
			timer_q     <= '0;
			ackw_q      <= 8'd0;
			op_q        <= 1'b0;
			reg_q       <= 8'd0;
			data_q      <= 8'd0;
			rx_q        <= 8'd0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q  <= step_n;
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				shift_q <= shift_n;
				timer_q <= timer_n;
				ackw_q  <= ackw_n;
				op_q    <= op_n;
				reg_q   <= reg_n;
				data_q  <= data_n;
				rx_q    <= rx_n;
				err_q   <= err_n;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.scl       <= scl_c;
			res_q.sda_out   <= sda_c;
			res_q.sda_drive <= drv_c;
			res_q.busy_res  <= (step_q != ST_IDLE);
			res_q.done_res  <= done;
			res_q.read_data <= rx_n;
			res_q.ack_error <= err_n;
		end
	end

endmodule

`default_nettype wire
